// File: sv/rdls_pkg.sv
// Shared types, constants and saturating arithmetic for the reaction-diffusion line step.
// No dependencies; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps

package rdls_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int FRACTION_BITS = 24;
  localparam int PROD_WIDTH    = 2 * VALUE_WIDTH;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [PROD_WIDTH:0]    prod_ext_t;

  localparam value_t VMAX = value_t'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
  localparam value_t VMIN = value_t'({1'b1, {(VALUE_WIDTH-1){1'b0}}});
  localparam value_t ONE  = (FRACTION_BITS >= VALUE_WIDTH - 1) ? VMAX
                          : value_t'(longint'(1) << FRACTION_BITS);
  localparam prod_ext_t HALF = prod_ext_t'(1) <<< (FRACTION_BITS - 1);

  localparam value_t RST_DIFF   = value_t'(167772);
  localparam value_t RST_DT     = value_t'(167772);
  localparam value_t RST_LATENT = value_t'(83886080);
  localparam value_t RST_LEFT   = value_t'(-16777216);

  typedef enum logic [1:0] {
    CFG_DIFF   = 2'd0,
    CFG_DT     = 2'd1,
    CFG_LATENT = 2'd2,
    CFG_LEFT   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MUL_DTL,
    MUL_DL,
    MUL_R,
    MUL_DTR,
    MUL_RL
  } mul_op_t;

  typedef enum logic [1:0] {
    OUT_BOUND,
    OUT_MID,
    OUT_LAST
  } out_sel_t;

  typedef struct packed {
    logic     capture;
    logic     shift;
    logic     pre;
    logic     mul_issue;
    mul_op_t  mul_op;
    logic     sum;
    logic     out_load;
    out_sel_t out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

  function automatic value_t sat_add(input value_t a, input value_t b);
    logic signed [VALUE_WIDTH:0] s;
    s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
    if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
      return s[VALUE_WIDTH] ? VMIN : VMAX;
    end
    return s[VALUE_WIDTH-1:0];
  endfunction

  function automatic value_t sat_sub(input value_t a, input value_t b);
    logic signed [VALUE_WIDTH:0] s;
    s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
    if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
      return s[VALUE_WIDTH] ? VMIN : VMAX;
    end
    return s[VALUE_WIDTH-1:0];
  endfunction

  // Round to nearest, ties away from zero, then clamp.
  function automatic value_t sat_round(input prod_t p);
    prod_ext_t s;
    prod_ext_t q;
    logic [PROD_WIDTH-VALUE_WIDTH+1:0] hi;
    s  = prod_ext_t'(p) + (p[PROD_WIDTH-1] ? (HALF - prod_ext_t'(1)) : HALF);
    q  = s >>> FRACTION_BITS;
    hi = q[PROD_WIDTH:VALUE_WIDTH-1];
    if (!((&hi) || !(|hi))) begin
      return q[PROD_WIDTH] ? VMIN : VMAX;
    end
    return q[VALUE_WIDTH-1:0];
  endfunction

endpackage

// File: sv/rdls_if.sv
// Stream channel interfaces for cells in and results out.
// Depends on rdls_pkg for the value type.
`timescale 1ns / 1ps

interface rdls_in_if;
  logic              valid;
  logic              ready;
  rdls_pkg::value_t  cell_temp;
  rdls_pkg::value_t  cell_phase;
  logic              last_cell;

  modport source(output valid, cell_temp, cell_phase, last_cell, input ready);
  modport sink(input valid, cell_temp, cell_phase, last_cell, output ready);
endinterface

interface rdls_out_if;
  logic              valid;
  logic              ready;
  rdls_pkg::value_t  new_temp;
  rdls_pkg::value_t  new_phase;
  logic              line_end;

  modport source(output valid, new_temp, new_phase, line_end, input ready);
  modport sink(input valid, new_temp, new_phase, line_end, output ready);
endinterface

// File: sv/rdls_dp.sv
// Datapath: config registers, cell window, shared multiplier with round/saturate stage,
// and the output register. Depends on rdls_pkg.
`timescale 1ns / 1ps

module rdls_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  rdls_pkg::value_t    cfg_data,
  input  rdls_pkg::value_t    cell_temp,
  input  rdls_pkg::value_t    cell_phase,
  input  logic                last_cell,
  input  rdls_pkg::dp_cmd_t   cmd,
  output rdls_pkg::dp_status_t status,
  output rdls_pkg::value_t    new_temp,
  output rdls_pkg::value_t    new_phase,
  output logic                line_end
);
  import rdls_pkg::*;

  value_t  diff, dt, latent, left_temp;
  value_t  tin, pin;
  logic    lastr;
  value_t  tl, tc, mp;
  value_t  pm1, lap;
  value_t  dtl, dl, r, np, rl, nt;
  value_t  mul_a, mul_b;
  prod_t   prod;
  value_t  mres;
  logic    wb_valid;
  mul_op_t wb_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff      <= RST_DIFF;
      dt        <= RST_DT;
      latent    <= RST_LATENT;
      left_temp <= RST_LEFT;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DIFF:   diff      <= cfg_data;
        CFG_DT:     dt        <= cfg_data;
        CFG_LATENT: latent    <= cfg_data;
        CFG_LEFT:   left_temp <= cfg_data;
        default:    diff      <= diff;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.mul_op)
      MUL_DTL: begin mul_a = dt;  mul_b = latent; end
      MUL_DL:  begin mul_a = diff; mul_b = lap;   end
      MUL_R:   begin mul_a = pm1; mul_b = tc;     end
      MUL_DTR: begin mul_a = dt;  mul_b = r;      end
      MUL_RL:  begin mul_a = dtl; mul_b = r;      end
      default: begin mul_a = dt;  mul_b = latent; end
    endcase
  end

  assign mres = sat_round(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
      wb_op    <= MUL_DTL;
      tl       <= '0;
      tc       <= '0;
      mp       <= '0;
    end else begin
      wb_valid <= cmd.mul_issue;
      wb_op    <= cmd.mul_op;
      if (cmd.shift) begin
        tl <= tc;
        tc <= tin;
        mp <= pin;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_t'(mul_a) * prod_t'(mul_b);
    if (cmd.capture) begin
      tin   <= cell_temp;
      pin   <= cell_phase;
      lastr <= last_cell;
    end
    if (cmd.pre) begin
      pm1 <= sat_sub(mp, ONE);
      lap <= sat_sub(sat_add(tin, tl), sat_add(tc, tc));
    end
    if (wb_valid) begin
      unique case (wb_op)
        MUL_DTL: dtl <= mres;
        MUL_DL:  dl  <= mres;
        MUL_R:   r   <= tc[VALUE_WIDTH-1] ? mres : '0;
        MUL_DTR: np  <= sat_add(mp, mres);
        MUL_RL:  rl  <= mres;
        default: dtl <= dtl;
      endcase
    end
    if (cmd.sum) begin
      nt <= sat_add(tc, sat_add(dl, rl));
    end
    if (cmd.out_load) begin
      unique case (cmd.out_sel)
        OUT_BOUND: begin new_temp <= left_temp; new_phase <= pin; line_end <= lastr; end
        OUT_MID:   begin new_temp <= nt;        new_phase <= np;  line_end <= 1'b0;  end
        OUT_LAST:  begin new_temp <= nt;        new_phase <= pin; line_end <= 1'b1;  end
        default:   begin new_temp <= nt;        new_phase <= np;  line_end <= 1'b0;  end
      endcase
    end
  end

  assign status.last = lastr;

endmodule

// File: sv/rdls_ctrl.sv
// Controller: handshakes, cell position tracking and the multiply schedule.
// Depends on rdls_pkg; drives the command struct of rdls_dp.
`timescale 1ns / 1ps

module rdls_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rdls_pkg::dp_status_t status,
  output rdls_pkg::dp_cmd_t    cmd
);
  import rdls_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PRE,
    ST_M_DL,
    ST_M_R,
    ST_WAIT_R,
    ST_M_DTR,
    ST_M_RL,
    ST_WAIT_RL,
    ST_SUM,
    ST_EMIT_B,
    ST_EMIT_M,
    ST_EMIT_L
  } state_t;

  typedef enum logic [1:0] {
    POS_FIRST,
    POS_SECOND,
    POS_STEADY
  } pos_t;

  state_t state;
  pos_t   pos;
  logic   slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.mul_op    = MUL_DTL;
    cmd.out_sel   = OUT_BOUND;
    cmd.capture   = in_valid && in_ready;
    unique case (state)
      ST_DISPATCH: cmd.shift = (pos == POS_SECOND) && !status.last;
      ST_PRE:      begin cmd.pre = 1'b1; cmd.mul_issue = 1'b1; cmd.mul_op = MUL_DTL; end
      ST_M_DL:     begin cmd.mul_issue = 1'b1; cmd.mul_op = MUL_DL;  end
      ST_M_R:      begin cmd.mul_issue = 1'b1; cmd.mul_op = MUL_R;   end
      ST_M_DTR:    begin cmd.mul_issue = 1'b1; cmd.mul_op = MUL_DTR; end
      ST_M_RL:     begin cmd.mul_issue = 1'b1; cmd.mul_op = MUL_RL;  end
      ST_SUM:      cmd.sum = 1'b1;
      ST_EMIT_B: begin
        cmd.out_load = slot_free;
        cmd.out_sel  = OUT_BOUND;
        cmd.shift    = slot_free && !status.last;
      end
      ST_EMIT_M: begin
        cmd.out_load = slot_free;
        cmd.out_sel  = OUT_MID;
        cmd.shift    = slot_free && !status.last;
      end
      ST_EMIT_L: begin
        cmd.out_load = slot_free;
        cmd.out_sel  = OUT_LAST;
      end
      default: cmd.sum = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= POS_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (in_valid) begin
          state <= ST_DISPATCH;
        end
        ST_DISPATCH: begin
          unique case (pos)
            POS_FIRST: begin
              state <= ST_EMIT_B;
              pos   <= status.last ? POS_FIRST : POS_SECOND;
            end
            POS_SECOND: begin
              if (status.last) begin
                state <= ST_EMIT_B;
                pos   <= POS_FIRST;
              end else begin
                state <= ST_IDLE;
                pos   <= POS_STEADY;
              end
            end
            default: state <= ST_PRE;
          endcase
        end
        ST_PRE:     state <= ST_M_DL;
        ST_M_DL:    state <= ST_M_R;
        ST_M_R:     state <= ST_WAIT_R;
        ST_WAIT_R:  state <= ST_M_DTR;
        ST_M_DTR:   state <= ST_M_RL;
        ST_M_RL:    state <= ST_WAIT_RL;
        ST_WAIT_RL: state <= ST_SUM;
        ST_SUM:     state <= ST_EMIT_M;
        ST_EMIT_B: if (slot_free) begin
          state <= ST_IDLE;
        end
        ST_EMIT_M: if (slot_free) begin
          if (status.last) begin
            state <= ST_EMIT_L;
            pos   <= POS_FIRST;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT_L: if (slot_free) begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending transfer");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_DISPATCH))
    else $error("accepted cell not dispatched");

  a_emit_last_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_L) |-> (pos == POS_FIRST))
    else $error("line end emitted without position reset");

  a_mul_in_compute: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_issue |-> (pos == POS_STEADY))
    else $error("multiply issued outside an interior cell");
`endif

endmodule

// File: sv/reaction_diffusion_line_step.sv
// Boundary results are loaded without any multiply; interior results pass through
// the multiply schedule. A new cell is accepted only in the idle state, so each cell
// is finished before the next is taken; the last cell emits two results. The single
// shared 32x32 multiplier with its round/saturate stage, used five times per interior
// cell, sets the pace; output stalls hold the controller in its emit states.
// Reset (synchronous, active high) loads register defaults and expects a line's first cell.
`timescale 1ns / 1ps

module reaction_diffusion_line_step_core (
  input  logic              clk,
  input  logic              rst,
  rdls_in_if.sink           cell_in,
  rdls_out_if.source        cell_out,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  rdls_pkg::value_t  cfg_data
);
  import rdls_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rdls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cell_in.valid),
    .in_ready  (cell_in.ready),
    .out_valid (cell_out.valid),
    .out_ready (cell_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rdls_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cell_temp  (cell_in.cell_temp),
    .cell_phase (cell_in.cell_phase),
    .last_cell  (cell_in.last_cell),
    .cmd        (cmd),
    .status     (status),
    .new_temp   (cell_out.new_temp),
    .new_phase  (cell_out.new_phase),
    .line_end   (cell_out.line_end)
  );

endmodule

// File: tb/sv/tb_reaction_diffusion_line_step_core.sv
// Self-checking bench for reaction_diffusion_line_step_core: lines of cells in, updated cells out.
// A scoreboard class predicts each result in Q8.24 and compares it field by field.
// Depends on rdls_pkg, rdls_if and the core RTL.
`timescale 1ns / 1ps

module tb_reaction_diffusion_line_step_core;
  import rdls_pkg::*;

  localparam int     FRAC             = 24;
  localparam value_t V_HI             = 32'sh7fff_ffff;
  localparam value_t V_LO             = value_t'(32'h8000_0000);
  localparam value_t UNIT             = 32'sh0100_0000;
  localparam value_t HALF_UNIT        = 32'sh0080_0000;
  localparam int     WATCHDOG_CYCLES  = 5000;
  localparam int     SETTLE_CYCLES    = 20;
  localparam int     ITEMS_PER_PHASE  = 125;
  localparam int     NUM_PHASES       = 8;
  localparam int     SINK_HOLD_CYCLES = 400;

  typedef struct packed {
    value_t temp;
    value_t phase;
    logic   line_end;
  } cell_result_t;

  typedef enum logic [1:0] {
    POS_FIRST,
    POS_SECOND,
    POS_STEADY
  } cell_pos_t;

  class line_step_scoreboard;
    value_t       diff_c, dt_c, latent_c, left_temp;
    value_t       left_t, mid_t, mid_phase;
    cell_pos_t    pos;
    cell_result_t expected_q[$];
    int           failures;

    function new();
      diff_c    = 167772;
      dt_c      = 167772;
      latent_c  = 83886080;
      left_temp = -16777216;
      left_t    = '0;
      mid_t     = '0;
      mid_phase = '0;
      pos       = POS_FIRST;
      failures  = 0;
    endfunction

    function value_t clip(longint x);
      if (x > longint'(V_HI)) return V_HI;
      if (x < longint'(V_LO)) return V_LO;
      return value_t'(x);
    endfunction

    function value_t add_clip(value_t a, value_t b);
      return clip(longint'(a) + longint'(b));
    endfunction

    function value_t sub_clip(value_t a, value_t b);
      return clip(longint'(a) - longint'(b));
    endfunction

    // round half away from zero on the magnitude
    function value_t mul_round(value_t a, value_t b);
      longint prod, mag, q;
      prod = longint'(a) * longint'(b);
      mag  = (prod < 0) ? -prod : prod;
      q    = (mag + (longint'(1) << (FRAC - 1))) >>> FRAC;
      return clip((prod < 0) ? -q : q);
    endfunction

    function void set_reg(cfg_idx_t idx, value_t v);
      case (idx)
        CFG_DIFF:   diff_c = v;
        CFG_DT:     dt_c = v;
        CFG_LATENT: latent_c = v;
        CFG_LEFT:   left_temp = v;
        default:    ;
      endcase
    endfunction

    function void note_cell(value_t t, value_t p, logic last);
      value_t r, np, nt, lap;
      case (pos)
        POS_FIRST: begin
          expected_q.push_back('{left_temp, p, last});
          if (!last) begin
            mid_t = t;
            pos   = POS_SECOND;
          end
        end
        POS_SECOND: begin
          if (last) begin
            expected_q.push_back('{left_temp, p, 1'b1});
            pos = POS_FIRST;
          end else begin
            left_t    = mid_t;
            mid_t     = t;
            mid_phase = p;
            pos       = POS_STEADY;
          end
        end
        default: begin
          r   = (mid_t < 0) ? mul_round(sub_clip(mid_phase, UNIT), mid_t) : '0;
          np  = add_clip(mid_phase, mul_round(dt_c, r));
          lap = sub_clip(add_clip(t, left_t), add_clip(mid_t, mid_t));
          nt  = add_clip(mid_t, add_clip(mul_round(diff_c, lap),
                                         mul_round(mul_round(dt_c, latent_c), r)));
          expected_q.push_back('{nt, np, 1'b0});
          if (last) begin
            expected_q.push_back('{nt, p, 1'b1});
            pos = POS_FIRST;
          end else begin
            left_t    = mid_t;
            mid_t     = t;
            mid_phase = p;
          end
        end
      endcase
    endfunction

    task report(string msg);
      if (failures < 100) $display("MISMATCH at %0t: %s", $time, msg);
      failures++;
    endtask

    task check_result(value_t t, value_t p, logic e);
      cell_result_t x;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result temp=%h phase=%h end=%b", t, p, e));
        return;
      end
      x = expected_q.pop_front();
      if (t !== x.temp) report($sformatf("new_temp %h, want %h", t, x.temp));
      if (p !== x.phase) report($sformatf("new_phase %h, want %h", p, x.phase));
      if (e !== x.line_end) report($sformatf("line_end %b, want %b", e, x.line_end));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst;
  logic     cfg_write;
  cfg_idx_t cfg_index;
  value_t   cfg_data;
  bit       gaps_on = 1'b1;
  bit       stall_on = 1'b1;
  bit       hold_go = 1'b0;
  bit       hold_seen = 1'b0;
  int       sink_hold = 0;
  int       idle_cycles = 0;

  line_step_scoreboard sb;

  rdls_in_if  in_ch();
  rdls_out_if out_ch();

  reaction_diffusion_line_step_core dut (
    .clk      (clk),
    .rst      (rst),
    .cell_in  (in_ch),
    .cell_out (out_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic value_t rand_temp();
    case ($urandom_range(0, 9))
      0:       return V_HI;
      1:       return V_LO;
      2:       return '0;
      3:       return UNIT;
      4:       return -UNIT;
      5, 6:    return value_t'($urandom());
      default: return value_t'($urandom_range(0, 32'h0800_0000) - 32'h0400_0000);
    endcase
  endfunction

  function automatic value_t rand_phase();
    case ($urandom_range(0, 7))
      0:       return V_HI;
      1:       return V_LO;
      2:       return UNIT;
      3, 4:    return value_t'($urandom());
      default: return value_t'($urandom_range(0, 32'h0100_0000));
    endcase
  endfunction

  task automatic send_cell(value_t t, value_t p, logic last);
    while (gaps_on && $urandom_range(0, 99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cell_temp  <= t;
    in_ch.cell_phase <= p;
    in_ch.last_cell  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_cell(t, p, last);
  endtask

  // drop valid, wait for all predicted results, then let the pipe settle
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, value_t v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic program_regs(value_t d, value_t s, value_t l, value_t b);
    write_reg(CFG_DIFF, d);
    write_reg(CFG_DT, s);
    write_reg(CFG_LATENT, l);
    write_reg(CFG_LEFT, b);
    cfg_write <= 1'b0;
  endtask

  task automatic run_random(int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(0, 19))
        0:       len = 1;
        1:       len = 2;
        2:       len = $urandom_range(20, 40);
        default: len = $urandom_range(3, 10);
      endcase
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 299) == 0) settle();
        send_cell(rand_temp(), rand_phase(), i == len - 1);
      end
      sent += len;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.new_temp, out_ch.new_phase, out_ch.line_end);
    end
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_go && !hold_seen) begin
      out_ch.ready <= 1'b0;
      hold_seen = 1'b1;
      sink_hold = SINK_HOLD_CYCLES - 1;
    end else if (sink_hold > 0) begin
      out_ch.ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      out_ch.ready <= !(stall_on && $urandom_range(0, 99) < 19);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb = new();
    rst              <= 1'b1;
    cfg_write        <= 1'b0;
    cfg_index        <= CFG_DIFF;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.cell_temp  <= '0;
    in_ch.cell_phase <= '0;
    in_ch.last_cell  <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-cell lines
    send_cell(V_HI, V_LO, 1'b1);
    send_cell(V_LO, V_HI, 1'b1);
    // two-cell line
    send_cell(V_LO, V_LO, 1'b0);
    send_cell(V_HI, UNIT, 1'b1);
    // three cells, saturating everywhere
    send_cell(V_LO, V_LO, 1'b0);
    send_cell(V_LO, V_LO, 1'b0);
    send_cell(V_HI, V_HI, 1'b1);
    // phase of exactly one, tiny negative temp, zero temp
    send_cell(V_HI, '0, 1'b0);
    send_cell(V_LO, UNIT, 1'b0);
    send_cell(V_HI, -UNIT, 1'b0);
    send_cell(value_t'(-1), V_HI, 1'b0);
    send_cell('0, '0, 1'b1);
    // pause mid-line until the pipe drains
    send_cell(-UNIT, HALF_UNIT, 1'b0);
    send_cell(-(UNIT + UNIT), HALF_UNIT, 1'b0);
    settle();
    send_cell('0, '0, 1'b0);
    send_cell(value_t'(-1), value_t'(-1), 1'b1);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      gaps_on  = (ph != 1);
      stall_on = (ph != 1);
      case (ph)
        1: program_regs(value_t'($urandom_range(0, 32'h0080_0000)),
                        value_t'($urandom_range(0, 32'h0019_9999)),
                        value_t'($urandom_range(0, 32'h0a00_0000)),
                        value_t'($urandom_range(0, 32'h0400_0000) - 32'h0200_0000));
        2: program_regs(V_HI, V_HI, V_HI, V_HI);
        3: program_regs(V_LO, V_LO, V_LO, V_LO);
        4: program_regs('0, '0, '0, '0);
        5, 6: program_regs(value_t'($urandom()), value_t'($urandom()),
                           value_t'($urandom()), value_t'($urandom()));
        7: program_regs(UNIT, V_HI, V_LO, '0);
        default: ;
      endcase
      if (ph == 0) hold_go = 1'b1;
      run_random(ITEMS_PER_PHASE);
      settle();
    end

    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/rdls_pkg.sv
sv/rdls_if.sv
sv/rdls_dp.sv
sv/rdls_ctrl.sv
sv/reaction_diffusion_line_step.sv
tb/sv/tb_reaction_diffusion_line_step_core.sv
